[design/ebml_pkg.sv]
`timescale 1ns / 1ps
package ebml_pkg;

	localparam int unsigned IdW   = 32;
	localparam int unsigned SizeW = 56;
	localparam int unsigned ValW  = 64;
	localparam int unsigned RateW = 30;
	localparam int unsigned ScanW = 17;

	localparam logic [7:0]       HdrByte    = 8'h1A;
	localparam logic [IdW-1:0]   IdEbml     = 32'h1A45DFA3;
	localparam logic [IdW-1:0]   IdSegment  = 32'h18538067;
	localparam logic [IdW-1:0]   IdInfo     = 32'h1549A966;
	localparam logic [IdW-1:0]   IdVideo    = 32'h000000E0;
	localparam logic [IdW-1:0]   IdAudio    = 32'h000000E1;
	localparam logic [IdW-1:0]   IdEntry    = 32'h000000AE;
	localparam logic [IdW-1:0]   IdTracks   = 32'h1654AE6B;
	localparam logic [IdW-1:0]   IdTrkType  = 32'h00000083;
	localparam logic [IdW-1:0]   IdDefDur   = 32'h0023E383;
	localparam logic [IdW-1:0]   IdPixW     = 32'h000000B0;
	localparam logic [IdW-1:0]   IdDispW    = 32'h000054B0;
	localparam logic [IdW-1:0]   IdPixH     = 32'h000000BA;
	localparam logic [IdW-1:0]   IdDispH    = 32'h000054BA;
	localparam logic [RateW-1:0] RateNum    = 30'd1000000000;
	localparam logic [ScanW-1:0] ScanReset  = 17'd32768;

	localparam logic [1:0] StDone   = 2'd0;
	localparam logic [1:0] StReject = 2'd1;
	localparam logic [1:0] StBadLen = 2'd2;
	localparam logic [1:0] StTrunc  = 2'd3;

	typedef struct packed {
		logic       id_load;
		logic       id_shift;
		logic       size_clr;
		logic       size_load;
		logic       size_shift;
		logic       pay_load;
		logic       pay_dec;
		logic       val_clr;
		logic       val_shift;
		logic       apply;
		logic       emit;
		logic [1:0] stat;
		logic       valid;
		logic       clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic id_is_ebml;
		logic id_is_cont;
		logic first_zero;
		logic first_int;
		logic more_zero;
		logic more_int;
		logic size_int;
		logic pay_one;
		logic busy;
		logic out_full;
	} dp_stat_t;

	function automatic logic [3:0] lead_zeros(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				n = 4'(7 - i);
			end
		end
		return n;
	endfunction

	function automatic logic is_int_len(input logic [SizeW-1:0] s);
		return (s == 56'd1) || (s == 56'd2) || (s == 56'd4) || (s == 56'd8);
	endfunction

endpackage

[design/ebml_ctrl.sv]
`timescale 1ns / 1ps
module ebml_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_data,
	input  logic [ebml_pkg::ScanW-1:0] scan_limit,
	input  logic                       scan_limit_we,
	input  ebml_pkg::dp_stat_t         st,
	output ebml_pkg::ctrl_cmd_t        cmd
);
	import ebml_pkg::*;

	typedef enum logic [2:0] {
		PH_SCAN, PH_ID_FIRST, PH_ID_MORE, PH_SIZE_FIRST, PH_SIZE_MORE, PH_PAYLOAD, PH_IDLE
	} phase_t;

	phase_t           phase_q, nphase, eph;
	logic [ScanW-1:0] limit_q, scan_q, nscan;
	logic [3:0]       hdr_q, nhdr, lz, hdr_dec;
	logic             hseen_q, nhseen, fin, fzero, fint;
	ctrl_cmd_t        c;

	always_comb begin
		c = '0;
		nphase = phase_q;
		nscan = scan_q;
		nhdr = hdr_q;
		nhseen = hseen_q;
		eph = phase_q;
		fin = 1'b0;
		fzero = 1'b0;
		fint = 1'b0;
		lz = lead_zeros(data_byte);
		hdr_dec = hdr_q - 4'd1;
		if (phase_q == PH_SCAN) begin
			if (scan_q >= limit_q) begin
				eph = PH_IDLE;
			end else begin
				nscan = scan_q + 1'b1;
				eph = (data_byte == HdrByte) ? PH_ID_FIRST : PH_SCAN;
			end
			nphase = eph;
		end
		case (eph)
			PH_ID_FIRST: begin
				c.id_load = 1'b1;
				c.size_clr = 1'b1;
				if (lz == 4'd8) begin
					nphase = PH_IDLE;
					c.emit = 1'b1;
					c.stat = StBadLen;
				end else begin
					nhdr = lz;
					nphase = (lz == 4'd0) ? PH_SIZE_FIRST : PH_ID_MORE;
					if (end_of_data) begin
						c.emit = 1'b1;
						c.stat = StTrunc;
					end
				end
			end
			PH_ID_MORE: begin
				c.id_shift = 1'b1;
				nhdr = hdr_dec;
				if (hdr_dec == 4'd0) begin
					nphase = PH_SIZE_FIRST;
				end
				if (end_of_data) begin
					c.emit = 1'b1;
					c.stat = StTrunc;
				end
			end
			PH_SIZE_FIRST: begin
				if (lz == 4'd8) begin
					nphase = PH_IDLE;
					c.emit = 1'b1;
					c.stat = StBadLen;
				end else begin
					c.size_load = 1'b1;
					nhdr = lz;
					if (lz == 4'd0) begin
						fin = 1'b1;
						fzero = st.first_zero;
						fint = st.first_int;
					end else begin
						nphase = PH_SIZE_MORE;
						if (end_of_data) begin
							c.emit = 1'b1;
							c.stat = StTrunc;
						end
					end
				end
			end
			PH_SIZE_MORE: begin
				c.size_shift = 1'b1;
				nhdr = hdr_dec;
				if (hdr_dec == 4'd0) begin
					fin = 1'b1;
					fzero = st.more_zero;
					fint = st.more_int;
				end else if (end_of_data) begin
					c.emit = 1'b1;
					c.stat = StTrunc;
				end
			end
			PH_PAYLOAD: begin
				c.val_shift = st.size_int;
				c.pay_dec = 1'b1;
				if (st.pay_one) begin
					c.apply = 1'b1;
					nphase = PH_ID_FIRST;
					c.emit = 1'b1;
					c.stat = StDone;
					c.valid = st.size_int;
				end else if (end_of_data) begin
					c.emit = 1'b1;
					c.stat = StTrunc;
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			c.emit = 1'b1;
			priority if (end_of_data) begin
				c.stat = StTrunc;
			end else if (st.id_is_ebml) begin
				nhseen = 1'b1;
				nphase = PH_ID_FIRST;
				c.stat = StDone;
			end else if (!hseen_q) begin
				nphase = PH_IDLE;
				c.stat = StReject;
			end else if (st.id_is_cont) begin
				nphase = PH_ID_FIRST;
				c.stat = StDone;
			end else if (fzero) begin
				c.apply = 1'b1;
				nphase = PH_ID_FIRST;
				c.stat = StDone;
			end else begin
				c.emit = 1'b0;
				c.pay_load = 1'b1;
				c.val_clr = fint;
				nphase = PH_PAYLOAD;
			end
		end
		c.clear = end_of_data;
	end

	assign cmd = acc ? c : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			scan_q <= '0;
			hdr_q <= '0;
			hseen_q <= 1'b0;
			limit_q <= ScanReset;
		end else begin
			if (scan_limit_we) begin
				limit_q <= scan_limit;
			end
			if (acc) begin
				if (end_of_data) begin
					phase_q <= PH_SCAN;
					scan_q <= '0;
					hdr_q <= '0;
					hseen_q <= 1'b0;
				end else begin
					phase_q <= nphase;
					scan_q <= nscan;
					hdr_q <= nhdr;
					hseen_q <= nhseen;
				end
			end
		end
	end

endmodule

[design/ebml_dpath.sv]
`timescale 1ns / 1ps
module ebml_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 data_byte,
	input  ebml_pkg::ctrl_cmd_t        cmd,
	input  logic                       out_stall,
	output ebml_pkg::dp_stat_t         st,
	output logic                       out_valid,
	output logic [ebml_pkg::IdW-1:0]   element_id,
	output logic [ebml_pkg::SizeW-1:0] element_size,
	output logic [ebml_pkg::ValW-1:0]  int_value,
	output logic                       value_valid,
	output logic                       video_found,
	output logic                       audio_found,
	output logic [31:0]                frame_width,
	output logic [31:0]                frame_height,
	output logic [ebml_pkg::RateW-1:0] frame_rate,
	output logic [1:0]                 status
);
	import ebml_pkg::*;

	logic [IdW-1:0]   id_q, id_n;
	logic [SizeW-1:0] size_q, size_n, size_first, size_more, pay_q;
	logic [ValW-1:0]  val_q, val_n;
	logic             vid_q, vid_n, aud_q, aud_n;
	logic [31:0]      wid_q, wid_n, hgt_q, hgt_n;
	logic [RateW-1:0] rate_q, rate_n;
	logic             div_go;
	logic [3:0]       lz;

	logic             ovalid_q;
	logic [IdW-1:0]   oid_q;
	logic [SizeW-1:0] osize_q;
	logic [ValW-1:0]  oval_q;
	logic             ovv_q, ovid_q, oaud_q;
	logic [31:0]      owid_q, ohgt_q;
	logic [RateW-1:0] orate_q;
	logic [1:0]       ostat_q;

	logic             busy_q, keep_q;
	logic [4:0]       dcnt_q;
	logic [RateW-1:0] dvd_q, rem_q, quo_q, rem_n, quo_fin;
	logic [ValW-1:0]  dvs_q;
	logic [RateW:0]   rem2;
	logic             ge;

	always_comb begin
		lz = lead_zeros(data_byte);
		size_first = {48'd0, data_byte & (8'h7F >> lz)};
		size_more = {size_q[SizeW-9:0], data_byte};
		id_n = cmd.id_load ? {24'd0, data_byte} :
			cmd.id_shift ? {id_q[IdW-9:0], data_byte} : id_q;
		priority if (cmd.size_clr) begin
			size_n = '0;
		end else if (cmd.size_load) begin
			size_n = size_first;
		end else if (cmd.size_shift) begin
			size_n = size_more;
		end else begin
			size_n = size_q;
		end
		priority if (cmd.val_clr) begin
			val_n = '0;
		end else if (cmd.val_shift) begin
			val_n = {val_q[ValW-9:0], data_byte};
		end else begin
			val_n = val_q;
		end
		vid_n = vid_q;
		aud_n = aud_q;
		wid_n = wid_q;
		hgt_n = hgt_q;
		rate_n = rate_q;
		div_go = 1'b0;
		if (cmd.apply) begin
			if (id_q == IdTrkType) begin
				if (val_n == 64'd1) begin
					vid_n = 1'b1;
				end else if (val_n == 64'd2) begin
					aud_n = 1'b1;
				end
			end
			if (id_q == IdDefDur) begin
				if (val_n == '0) begin
					rate_n = '0;
				end else begin
					div_go = 1'b1;
				end
			end
			if (id_q == IdPixW || id_q == IdDispW) begin
				wid_n = val_n[31:0];
			end
			if (id_q == IdPixH || id_q == IdDispH) begin
				hgt_n = val_n[31:0];
			end
		end
		rem2 = {rem_q, dvd_q[RateW-1]};
		ge = {33'd0, rem2} >= dvs_q;
		rem_n = ge ? RateW'(rem2 - dvs_q[RateW:0]) : rem2[RateW-1:0];
		quo_fin = {quo_q[RateW-2:0], ge};
	end

	always_comb begin
		st.id_is_ebml = id_q == IdEbml;
		st.id_is_cont = id_q == IdSegment || id_q == IdInfo || id_q == IdVideo ||
			id_q == IdAudio || id_q == IdEntry || id_q == IdTracks;
		st.first_zero = size_first == '0;
		st.first_int = is_int_len(size_first);
		st.more_zero = size_more == '0;
		st.more_int = is_int_len(size_more);
		st.size_int = is_int_len(size_q);
		st.pay_one = pay_q == 56'd1;
		st.busy = busy_q;
		st.out_full = ovalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0;
			size_q <= '0;
			pay_q <= '0;
			val_q <= '0;
			vid_q <= 1'b0;
			aud_q <= 1'b0;
			wid_q <= '0;
			hgt_q <= '0;
			rate_q <= '0;
			ovalid_q <= 1'b0;
			busy_q <= 1'b0;
			keep_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.clear) begin
				id_q <= '0;
				size_q <= '0;
				pay_q <= '0;
				val_q <= '0;
				vid_q <= 1'b0;
				aud_q <= 1'b0;
				wid_q <= '0;
				hgt_q <= '0;
				rate_q <= '0;
			end else begin
				id_q <= id_n;
				size_q <= size_n;
				val_q <= val_n;
				vid_q <= vid_n;
				aud_q <= aud_n;
				wid_q <= wid_n;
				hgt_q <= hgt_n;
				rate_q <= rate_n;
				if (cmd.pay_load) begin
					pay_q <= size_n;
				end else if (cmd.pay_dec) begin
					pay_q <= pay_q - 1'b1;
				end
			end
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.emit) begin
				ovalid_q <= !div_go;
				oid_q <= id_n;
				osize_q <= size_n;
				oval_q <= val_n;
				ovv_q <= cmd.valid;
				ovid_q <= vid_n;
				oaud_q <= aud_n;
				owid_q <= wid_n;
				ohgt_q <= hgt_n;
				orate_q <= rate_n;
				ostat_q <= cmd.stat;
			end
			if (div_go) begin
				busy_q <= 1'b1;
				keep_q <= !cmd.clear;
				dcnt_q <= '0;
				dvd_q <= RateNum;
				rem_q <= '0;
				quo_q <= '0;
				dvs_q <= val_n;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[RateW-2:0], 1'b0};
				rem_q <= rem_n;
				quo_q <= quo_fin;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 5'(RateW - 1)) begin
					busy_q <= 1'b0;
					ovalid_q <= 1'b1;
					orate_q <= quo_fin;
					if (keep_q) begin
						rate_q <= quo_fin;
					end
				end
			end
		end
	end

	assign out_valid = ovalid_q;
	assign element_id = oid_q;
	assign element_size = osize_q;
	assign int_value = oval_q;
	assign value_valid = ovv_q;
	assign video_found = ovid_q;
	assign audio_found = oaud_q;
	assign frame_width = owid_q;
	assign frame_height = ohgt_q;
	assign frame_rate = orate_q;
	assign status = ostat_q;

endmodule

[design/ebml_element_stream_parser_unit.sv]
`timescale 1ns / 1ps
// One byte per cycle unless stalled; each result is registered from the byte that causes it.
// A DefaultDuration element with a nonzero value runs the restoring divider
// (one quotient bit per cycle); input stalls meanwhile.
// Input also stalls while a result is held and the output is stalled.
// Reset (arst_n low) clears all parse state and sets scan_limit to 32768.
module ebml_element_stream_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       scan_limit_we,
	input  logic [ebml_pkg::ScanW-1:0] scan_limit,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ebml_pkg::IdW-1:0]   element_id,
	output logic [ebml_pkg::SizeW-1:0] element_size,
	output logic [ebml_pkg::ValW-1:0]  int_value,
	output logic                       value_valid,
	output logic                       video_found,
	output logic                       audio_found,
	output logic [31:0]                frame_width,
	output logic [31:0]                frame_height,
	output logic [ebml_pkg::RateW-1:0] frame_rate,
	output logic [1:0]                 status
);
	import ebml_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  st;
	logic      acc;

	assign in_stall = st.busy || (st.out_full && out_stall);
	assign acc = in_valid && !in_stall;

	ebml_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.data_byte(data_byte),
		.end_of_data(end_of_data),
		.scan_limit(scan_limit),
		.scan_limit_we(scan_limit_we),
		.st(st),
		.cmd(cmd)
	);

	ebml_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.cmd(cmd),
		.out_stall(out_stall),
		.st(st),
		.out_valid(out_valid),
		.element_id(element_id),
		.element_size(element_size),
		.int_value(int_value),
		.value_valid(value_valid),
		.video_found(video_found),
		.audio_found(audio_found),
		.frame_width(frame_width),
		.frame_height(frame_height),
		.frame_rate(frame_rate),
		.status(status)
	);

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		st.busy |-> in_stall) else $error("input taken during divide");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_rate <= RateNum) else $error("frame rate out of range");

	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st.busy |-> !out_valid) else $error("result shown before divide done");

	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && value_valid) |-> status == StDone) else $error("valid value on error");

endmodule

[bench/tb_ebml_element_stream_parser_unit.sv]
`timescale 1ns / 1ps
module tb_ebml_element_stream_parser_unit;
	import ebml_pkg::*;

	typedef enum logic [2:0] {
		PhScan, PhIdFirst, PhIdMore, PhSizeFirst, PhSizeMore, PhPayload, PhIdle
	} phase_e;

	typedef struct {
		logic [IdW-1:0]   id;
		logic [SizeW-1:0] size;
		logic [ValW-1:0]  val;
		logic             vv;
		logic             vid;
		logic             aud;
		logic [31:0]      w;
		logic [31:0]      h;
		logic [RateW-1:0] rate;
		logic [1:0]       st;
	} elem_t;

	typedef struct {
		logic [7:0] b;
		logic       eod;
		logic       chk;
		logic [1:0] st;
	} byte_t;

	logic clk, arst_n;
	logic scan_limit_we;
	logic [ScanW-1:0] scan_limit;
	logic in_valid, in_stall;
	logic [7:0] data_byte;
	logic end_of_data;
	logic out_valid, out_stall;
	logic [IdW-1:0] element_id;
	logic [SizeW-1:0] element_size;
	logic [ValW-1:0] int_value;
	logic value_valid, video_found, audio_found;
	logic [31:0] frame_width, frame_height;
	logic [RateW-1:0] frame_rate;
	logic [1:0] status;

	ebml_element_stream_parser_unit dut (
		.clk(clk), .arst_n(arst_n),
		.scan_limit_we(scan_limit_we), .scan_limit(scan_limit),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_data(end_of_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.element_id(element_id), .element_size(element_size),
		.int_value(int_value), .value_valid(value_valid),
		.video_found(video_found), .audio_found(audio_found),
		.frame_width(frame_width), .frame_height(frame_height),
		.frame_rate(frame_rate), .status(status)
	);

	// parser shadow state
	logic [ScanW-1:0] m_limit;
	phase_e           m_phase;
	logic [ScanW-1:0] m_scan;
	logic [3:0]       m_hdr_left;
	logic [IdW-1:0]   m_id;
	logic [SizeW-1:0] m_size;
	logic [SizeW-1:0] m_pay_left;
	logic [ValW-1:0]  m_val;
	logic m_hdr_seen, m_vid, m_aud;
	logic [31:0] m_w, m_h;
	logic [RateW-1:0] m_rate;

	elem_t elem_q[$];
	byte_t stim_q[$];
	int emitted;
	logic [1:0] last_st;
	int errors;
	int idle_cycles;
	bit burst_mode;
	int burst_left;
	int stall_mode;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int lead_z(logic [7:0] b);
		int n;
		n = 8;
		for (int i = 0; i < 8; i++)
			if (b[i]) n = 7 - i;
		return n;
	endfunction

	function automatic bit int_len(logic [SizeW-1:0] s);
		return s == 1 || s == 2 || s == 4 || s == 8;
	endfunction

	function automatic bit is_cont(logic [IdW-1:0] id);
		return id == IdSegment || id == IdInfo || id == IdVideo || id == IdAudio ||
			id == IdEntry || id == IdTracks;
	endfunction

	task automatic clear_parse();
		m_phase = PhScan;
		m_scan = 0;
		m_hdr_left = 0;
		m_id = 0;
		m_size = 0;
		m_pay_left = 0;
		m_val = 0;
		m_hdr_seen = 0;
		m_vid = 0;
		m_aud = 0;
		m_w = 0;
		m_h = 0;
		m_rate = 0;
	endtask

	task automatic push_elem(logic [1:0] st, logic vv);
		elem_t e;
		e.id = m_id;
		e.size = m_size;
		e.val = m_val;
		e.vv = vv;
		e.vid = m_vid;
		e.aud = m_aud;
		e.w = m_w;
		e.h = m_h;
		e.rate = m_rate;
		e.st = st;
		elem_q.push_back(e);
		emitted++;
		last_st = st;
	endtask

	task automatic update_track();
		case (m_id)
			IdTrkType: begin
				if (m_val == 1) m_vid = 1;
				else if (m_val == 2) m_aud = 1;
			end
			IdDefDur: m_rate = (m_val == 0) ? '0 : RateW'(64'd1000000000 / m_val);
			IdPixW, IdDispW: m_w = m_val[31:0];
			IdPixH, IdDispH: m_h = m_val[31:0];
			default: ;
		endcase
	endtask

	task automatic header_done(logic last);
		if (last) begin
			push_elem(StTrunc, 0);
		end else if (m_id == IdEbml) begin
			m_hdr_seen = 1;
			m_phase = PhIdFirst;
			push_elem(StDone, 0);
		end else if (!m_hdr_seen) begin
			m_phase = PhIdle;
			push_elem(StReject, 0);
		end else if (is_cont(m_id)) begin
			m_phase = PhIdFirst;
			push_elem(StDone, 0);
		end else if (m_size == 0) begin
			update_track();
			m_phase = PhIdFirst;
			push_elem(StDone, 0);
		end else begin
			m_pay_left = m_size;
			if (int_len(m_size)) m_val = 0;
			m_phase = PhPayload;
		end
	endtask

	task automatic parse_byte(logic [7:0] b, logic last);
		int lz;
		if (m_phase == PhScan) begin
			if (m_scan >= m_limit) begin
				m_phase = PhIdle;
			end else begin
				m_scan++;
				if (b == HdrByte) m_phase = PhIdFirst;
			end
		end
		case (m_phase)
			PhIdFirst: begin
				lz = lead_z(b);
				m_id = {24'd0, b};
				m_size = 0;
				if (lz >= 8) begin
					m_phase = PhIdle;
					push_elem(StBadLen, 0);
				end else begin
					m_hdr_left = 4'(lz);
					m_phase = (lz == 0) ? PhSizeFirst : PhIdMore;
					if (last) push_elem(StTrunc, 0);
				end
			end
			PhIdMore: begin
				m_id = {m_id[23:0], b};
				m_hdr_left = m_hdr_left - 4'd1;
				if (m_hdr_left == 0) m_phase = PhSizeFirst;
				if (last) push_elem(StTrunc, 0);
			end
			PhSizeFirst: begin
				lz = lead_z(b);
				if (lz >= 8) begin
					m_phase = PhIdle;
					push_elem(StBadLen, 0);
				end else begin
					m_size = SizeW'(b & (8'h7F >> lz));
					m_hdr_left = 4'(lz);
					if (lz == 0) begin
						header_done(last);
					end else begin
						m_phase = PhSizeMore;
						if (last) push_elem(StTrunc, 0);
					end
				end
			end
			PhSizeMore: begin
				m_size = {m_size[SizeW-9:0], b};
				m_hdr_left = m_hdr_left - 4'd1;
				if (m_hdr_left == 0) header_done(last);
				else if (last) push_elem(StTrunc, 0);
			end
			PhPayload: begin
				if (int_len(m_size)) m_val = {m_val[ValW-9:0], b};
				m_pay_left = m_pay_left - SizeW'(1);
				if (m_pay_left == 0) begin
					update_track();
					m_phase = PhIdFirst;
					push_elem(StDone, int_len(m_size));
				end else if (last) begin
					push_elem(StTrunc, 0);
				end
			end
			default: ;
		endcase
		if (last) clear_parse();
	endtask

	task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		elem_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (elem_q.size() == 0) begin
					$display("%0t unexpected element: actual id %h status %0d",
						$time, element_id, status);
					errors++;
				end else begin
					e = elem_q.pop_front();
					cmp("element_id", e.id, element_id);
					cmp("element_size", e.size, element_size);
					cmp("int_value", e.val, int_value);
					cmp("value_valid", e.vv, value_valid);
					cmp("video_found", e.vid, video_found);
					cmp("audio_found", e.aud, audio_found);
					cmp("frame_width", e.w, frame_width);
					cmp("frame_height", e.h, frame_height);
					cmp("frame_rate", e.rate, frame_rate);
					cmp("status", e.st, status);
				end
			end
			if (in_valid && !in_stall) parse_byte(data_byte, end_of_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= 5000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver stall runs
	initial begin
		int run;
		out_stall = 0;
		run = 0;
		forever begin
			@(negedge clk);
			if (run > 0) begin
				run--;
			end else begin
				run = $urandom_range(0, 12);
				case (stall_mode)
					0: out_stall = 0;
					1: out_stall = ~out_stall;
					default: out_stall = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send(byte_t it);
		if (burst_mode) begin
			if (burst_left == 0) begin
				in_valid = 0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
		end
		in_valid = 1;
		data_byte = it.b;
		end_of_data = it.eod;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic add(logic [7:0] b);
		byte_t it;
		it.b = b;
		it.eod = 0;
		it.chk = 0;
		it.st = StDone;
		stim_q.push_back(it);
	endtask

	task automatic add_size(logic [63:0] s, int w);
		logic [63:0] v;
		v = s | (64'd1 << (7 + 7 * w));
		for (int i = w; i >= 0; i--) add(v[8*i +: 8]);
	endtask

	task automatic add_id(logic [IdW-1:0] id);
		bit on;
		on = 0;
		for (int i = 3; i >= 0; i--) begin
			if (id[8*i +: 8] != 0) on = 1;
			if (on) add(id[8*i +: 8]);
		end
	endtask

	// returns 1 when the element leaves the stream unparseable
	task automatic add_elem(output bit stop);
		int sel, w, s;
		logic [7:0] b;
		logic [IdW-1:0] ids[13];
		ids = '{IdSegment, IdInfo, IdTracks, IdEntry, IdVideo, IdAudio, IdTrkType,
			IdDefDur, IdPixW, IdDispW, IdPixH, IdDispH, IdEbml};
		stop = 0;
		sel = $urandom_range(0, 19);
		if (sel < 13) begin
			add_id(ids[sel]);
		end else if (sel == 13) begin
			add(8'h00);
			stop = 1;
			return;
		end else begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
			b = 8'($urandom());
			add((b & (8'h7F >> w)) | (8'h80 >> w));
			repeat (w) add(8'($urandom()));
		end
		case ($urandom_range(0, 15))
			0: begin
				w = $urandom_range(0, 7);
				b = 8'($urandom());
				add((b & (8'h7F >> w)) | (8'h80 >> w));
				repeat (w) add(8'($urandom()));
				repeat ($urandom_range(0, 4)) add(8'($urandom()));
				stop = 1;
				return;
			end
			1: begin
				add(8'h00);
				stop = 1;
				return;
			end
			2, 3, 4: s = $urandom_range(0, 12);
			default: begin
				case ($urandom_range(0, 3))
					0: s = 1;
					1: s = 2;
					2: s = 4;
					default: s = 8;
				endcase
			end
		endcase
		if (sel < 6 && $urandom_range(0, 1)) s = 0;
		add_size(s, $urandom_range(0, 1) ? 0 : $urandom_range(1, 7));
		if (sel >= 6 && sel < 13) begin
			for (int i = 0; i < s; i++) begin
				if (sel == 6 && s == 1) add(8'($urandom_range(0, 3)));
				else if (sel == 7 && i < s - 3 && $urandom_range(0, 1)) add(8'h00);
				else add(8'($urandom()));
			end
		end
	endtask

	task automatic add_file();
		int start, n, cut;
		bit stop;
		start = stim_q.size();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) begin
				n = $urandom_range(0, 255);
				add((n == HdrByte) ? 8'h1B : 8'(n));
			end
		if ($urandom_range(0, 9) == 0) begin
			add(HdrByte);
			repeat (3) add(8'($urandom()));
			add_size($urandom_range(0, 3), 0);
		end else begin
			add_id(IdEbml);
			add_size($urandom_range(0, 3), 0);
		end
		n = $urandom_range(1, 14);
		stop = 0;
		while (n > 0 && !stop) begin
			add_elem(stop);
			n--;
		end
		if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 5)) add(8'($urandom()));
		if ($urandom_range(0, 4) == 0) begin
			cut = start + $urandom_range(1, stim_q.size() - start);
			while (stim_q.size() > cut) void'(stim_q.pop_back());
		end
		stim_q[stim_q.size() - 1].eod = 1;
	endtask

	task automatic settle_and_cfg(logic [ScanW-1:0] lim);
		in_valid = 0;
		while (elem_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		scan_limit_we = 1;
		scan_limit = lim;
		@(negedge clk);
		scan_limit_we = 0;
		m_limit = lim;
	endtask

	byte_t dir_tab[] = '{
		'{8'h1A, 0, 0, StDone}, '{8'h45, 0, 0, StDone}, '{8'hDF, 0, 0, StDone},
		'{8'hA3, 0, 0, StDone}, '{8'h80, 0, 1, StDone},
		'{8'hB0, 0, 0, StDone}, '{8'h81, 0, 0, StDone}, '{8'hFF, 0, 1, StDone},
		'{8'h83, 0, 0, StDone}, '{8'h81, 0, 0, StDone}, '{8'h01, 0, 1, StDone},
		'{8'h23, 0, 0, StDone}, '{8'hE3, 0, 0, StDone}, '{8'h83, 0, 0, StDone},
		'{8'h81, 0, 0, StDone}, '{8'h07, 0, 1, StDone},
		'{8'hAE, 0, 0, StDone}, '{8'h85, 0, 1, StDone},
		'{8'h00, 0, 1, StBadLen}, '{8'h55, 1, 0, StDone},
		'{8'h1A, 1, 1, StTrunc},
		'{8'h1A, 0, 0, StDone}, '{8'h45, 0, 0, StDone}, '{8'hDF, 0, 0, StDone},
		'{8'hA2, 0, 0, StDone}, '{8'h81, 0, 1, StReject}, '{8'h00, 1, 0, StDone}
	};

	initial begin
		int prior_cnt;
		logic [ScanW-1:0] limits[6];
		arst_n = 0;
		scan_limit_we = 0;
		scan_limit = ScanReset;
		in_valid = 0;
		data_byte = 0;
		end_of_data = 0;
		errors = 0;
		emitted = 0;
		idle_cycles = 0;
		burst_mode = 0;
		burst_left = 0;
		stall_mode = 0;
		m_limit = ScanReset;
		clear_parse();
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			prior_cnt = emitted;
			send(dir_tab[i]);
			if (dir_tab[i].chk && (emitted != prior_cnt + 1 || last_st != dir_tab[i].st)) begin
				$display("%0t directed byte %0d: expected status %0d actual %0d",
					$time, i, dir_tab[i].st, (emitted == prior_cnt) ? -1 : int'(last_st));
				errors++;
			end
		end

		limits = '{17'd1, 17'd65536, 17'($urandom_range(2, 8)),
			17'($urandom_range(1, 65536)), 17'd3, ScanReset};
		foreach (limits[p]) begin
			settle_and_cfg(limits[p]);
			burst_mode = (p % 3) != 0;
			stall_mode = p % 3;
			while (stim_q.size() < 340) add_file();
			while (stim_q.size() != 0) send(stim_q.pop_front());
		end

		in_valid = 0;
		while (elem_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0 && elem_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
